// ===== rtl/consistent_hash_ring_lookup_core_assert.svh =====
// Assertion macros for the ring lookup core
`ifndef CONSISTENT_HASH_RING_LOOKUP_CORE_ASSERT_SVH
`define CONSISTENT_HASH_RING_LOOKUP_CORE_ASSERT_SVH
`define CHR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/chrl_pkg.sv =====
// ----------------------------------------------------------------------------
// chrl_pkg
// Shared types and constants for the consistent hash ring lookup core.
// ----------------------------------------------------------------------------
package chrl_pkg;
   localparam int MaxEntriesDefault = 4096;
   localparam int MaxServersDefault = 32;
   localparam int HashW = 32;
   localparam int SrvW = 5;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] CSR_FAILOVER  = 2'd0;
   localparam logic [1:0] CSR_ALIVE     = 2'd1;
   localparam logic [1:0] CSR_RECONNECT = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [HashW-1:0] hash_word;
      logic [SrvW-1:0]  server_index;
      logic             liveness_req;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [SrvW-1:0] found_server;
   } rsp_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NOP, CMD_LOAD, CMD_CLEAR, CMD_SRCH_INIT, CMD_SRCH_RD, CMD_SRCH_STEP,
      CMD_SHIFT_RD, CMD_SHIFT_WR, CMD_PUT, CMD_LK_RD, CMD_LK_ORIG,
      CMD_WALK_RD, CMD_WALK_CHK
   } cmd_type;

   typedef struct packed {
      logic srch_done;
      logic empty;
      logic full;
      logic bad_server;
      logic shift_done;
      logic orig_ok;
      logic walk_hit;
      logic walk_done;
      logic failover;
      logic recon_orig;
   } stat_type;
endpackage

// ===== rtl/chrl_if.sv =====
// ----------------------------------------------------------------------------
// chrl_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface chrl_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/chrl_datapath.sv =====
// ----------------------------------------------------------------------------
// chrl_datapath
// Ring memory, search bounds, shift pointer and failover walk pointer.
// ----------------------------------------------------------------------------
module chrl_datapath
   import chrl_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntriesDefault,
   parameter int MAX_SERVERS = MaxServersDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req,
   input  logic             fail_en,
   input  logic [31:0]      alive,
   input  logic [31:0]      recon,
   output stat_type         stat,
   output logic [SrvW-1:0]  orig_server
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_ENTRIES);

   logic [HashW+SrvW-1:0] mem [MAX_ENTRIES];
   logic [HashW+SrvW-1:0] rd_ff;
   logic [CW-1:0] count_ff, lo_ff, hi_ff, ptr_ff, steps_ff;
   logic [HashW-1:0] key_ff;
   logic [SrvW-1:0] srv_ff, orig_ff;
   logic strict_ff, check_ff;

   logic [CW-1:0] mid, wrap_next;
   logic [HashW-1:0] rd_hash;
   logic [SrvW-1:0] rd_srv;
   logic go_right;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_hash = rd_ff[HashW+SrvW-1:SrvW];
   assign rd_srv = rd_ff[SrvW-1:0];
   assign go_right = strict_ff ? (rd_hash <= key_ff) : (rd_hash < key_ff);
   assign wrap_next = (ptr_ff + 1'b1 >= count_ff) ? '0 : ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd == CMD_CLEAR) begin
         count_ff <= '0;
      end else if (cmd == CMD_PUT) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            key_ff <= req.hash_word;
            srv_ff <= req.server_index;
            check_ff <= req.liveness_req;
            strict_ff <= (req.func == FUNC_INSERT);
         end
         CMD_SRCH_INIT: begin
            lo_ff <= '0;
            hi_ff <= count_ff;
            // start the shift at the tail
            ptr_ff <= count_ff;
         end
         CMD_SRCH_RD: rd_ff <= mem[mid[AW-1:0]];
         CMD_SRCH_STEP: begin
            if (go_right) lo_ff <= mid + 1'b1;
            else hi_ff <= mid;
         end
         CMD_SHIFT_RD: rd_ff <= mem[AW'(ptr_ff - 1'b1)];
         CMD_SHIFT_WR: begin
            mem[ptr_ff[AW-1:0]] <= rd_ff;
            ptr_ff <= ptr_ff - 1'b1;
         end
         CMD_PUT: mem[lo_ff[AW-1:0]] <= {key_ff, srv_ff};
         CMD_LK_RD: begin
            if (lo_ff >= count_ff) begin
               rd_ff <= mem[0];
               ptr_ff <= '0;
            end else begin
               rd_ff <= mem[lo_ff[AW-1:0]];
               ptr_ff <= lo_ff;
            end
            steps_ff <= '0;
         end
         CMD_LK_ORIG: orig_ff <= rd_srv;
         CMD_WALK_RD: begin
            rd_ff <= mem[wrap_next[AW-1:0]];
            ptr_ff <= wrap_next;
            steps_ff <= steps_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat = '0;
      stat.srch_done = (lo_ff >= hi_ff);
      stat.empty = (count_ff == '0);
      stat.full = (count_ff >= MaxCnt);
      stat.bad_server = ({27'd0, srv_ff} >= 32'(MAX_SERVERS));
      stat.shift_done = (ptr_ff <= lo_ff);
      stat.orig_ok = !check_ff || alive[rd_srv];
      stat.walk_hit = (rd_srv != orig_ff) && recon[rd_srv];
      stat.walk_done = (steps_ff >= count_ff);
      stat.failover = fail_en;
      stat.recon_orig = recon[orig_ff];
   end

   assign orig_server = (cmd == CMD_WALK_CHK || cmd == CMD_LK_ORIG) ? rd_srv : orig_ff;
endmodule

// ===== rtl/chrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// chrl_ctrl
// Sequencer for clear, insert and lookup requests; owns the response register.
// ----------------------------------------------------------------------------
module chrl_ctrl
   import chrl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp,
   output cmd_type         cmd,
   input  stat_type        stat,
   input  logic [SrvW-1:0] sel_server
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SRD, S_SSTEP, S_SHRD, S_SHWR, S_LKRD, S_LKORIG,
      S_WRD, S_WCHK, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] func_ff, func_in;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      func_in = func_ff;
      rsp_in = rsp_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd = CMD_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd = CMD_LOAD;
               func_in = req.func;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            rsp_in = '{status: ST_OK, found_server: '0};
            state_in = S_RESP;
            case (func_ff)
               FUNC_CLEAR: cmd = CMD_CLEAR;
               FUNC_INSERT: begin
                  if (stat.bad_server) rsp_in.status = ST_NONE;
                  else if (stat.full) rsp_in.status = ST_FULL;
                  else begin
                     cmd = CMD_SRCH_INIT;
                     state_in = S_SRD;
                  end
               end
               FUNC_LOOKUP: begin
                  if (stat.empty) rsp_in.status = ST_NONE;
                  else begin
                     cmd = CMD_SRCH_INIT;
                     state_in = S_SRD;
                  end
               end
               default: ;
            endcase
         end
         S_SRD: begin
            if (stat.srch_done) begin
               state_in = (func_ff == FUNC_INSERT) ? S_SHRD : S_LKRD;
            end else begin
               cmd = CMD_SRCH_RD;
               state_in = S_SSTEP;
            end
         end
         S_SSTEP: begin
            cmd = CMD_SRCH_STEP;
            state_in = S_SRD;
         end
         S_SHRD: begin
            if (stat.shift_done) begin
               cmd = CMD_PUT;
               rsp_in = '{status: ST_OK, found_server: '0};
               state_in = S_RESP;
            end else begin
               cmd = CMD_SHIFT_RD;
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd = CMD_SHIFT_WR;
            state_in = S_SHRD;
         end
         S_LKRD: begin
            cmd = CMD_LK_RD;
            state_in = S_LKORIG;
         end
         S_LKORIG: begin
            cmd = CMD_LK_ORIG;
            state_in = S_RESP;
            if (stat.orig_ok) begin
               rsp_in = '{status: ST_OK, found_server: sel_server};
            end else if (stat.failover) begin
               state_in = S_WRD;
            end else begin
               state_in = S_WCHK;
            end
         end
         S_WRD: begin
            if (stat.walk_done) begin
               rsp_in = '{status: ST_NONE, found_server: '0};
               state_in = S_RESP;
            end else begin
               cmd = CMD_WALK_RD;
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            // no failover: origin must reconnect
            if (!stat.failover) begin
               if (stat.recon_orig) rsp_in = '{status: ST_OK, found_server: sel_server};
               else rsp_in = '{status: ST_NONE, found_server: '0};
               state_in = S_RESP;
            end else begin
               cmd = CMD_WALK_CHK;
               if (stat.walk_hit) begin
                  rsp_in = '{status: ST_OK, found_server: sel_server};
                  state_in = S_RESP;
               end else begin
                  state_in = S_WRD;
               end
            end
         end
         S_RESP: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      func_ff <= func_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ===== rtl/consistent_hash_ring_lookup_core.sv =====
// Clear resets the entry count; insert runs a binary search, shifts later
// entries up one at a time and writes the new entry; lookup runs a binary
// search and, when the liveness check fails, checks the origin for reconnect
// or walks the ring on failover. Requests are handled one at a time: a new
// one is taken only after the response has been accepted.
// Reset: synchronous, clears the entry count and restores register defaults.
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_core
// Sorted hash ring with binary search lookup and server failover walk.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_core
   import chrl_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntriesDefault,
   parameter int MAX_SERVERS = MaxServersDefault
) (
   input  logic        clock,
   input  logic        reset,
   chrl_if.sink        req_ch,
   chrl_if.source      rsp_ch,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   logic fail_en_ff;
   logic [31:0] alive_ff, recon_ff;
   cmd_type cmd;
   stat_type stat;
   logic [SrvW-1:0] sel_server;
   req_type req_pl;
   rsp_type rsp_pl;

   assign req_pl = req_ch.payload;
   assign rsp_ch.payload = rsp_pl;

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_en_ff <= 1'b0;
         alive_ff <= '1;
         recon_ff <= '1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FAILOVER: fail_en_ff <= csr_write_data[0];
            CSR_ALIVE: alive_ff <= csr_write_data;
            CSR_RECONNECT: recon_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   chrl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req(req_pl),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp(rsp_pl),
      .cmd(cmd), .stat(stat), .sel_server(sel_server)
   );

   chrl_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_SERVERS(MAX_SERVERS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_pl),
      .fail_en(fail_en_ff), .alive(alive_ff), .recon(recon_ff),
      .stat(stat), .orig_server(sel_server)
   );
endmodule

// ===== rtl/chrl_checker.sv =====
// ----------------------------------------------------------------------------
// chrl_checker
// Port-level checks on the ring lookup core.
// ----------------------------------------------------------------------------
`include "consistent_hash_ring_lookup_core_assert.svh"
module chrl_checker
   import chrl_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp
);
   `CHR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
   `CHR_ASSERT_NXT(a_one_out, clock, reset, req_valid && req_ready, !req_ready)
   `CHR_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp.status <= ST_FULL)
   `CHR_ASSERT_IMP(a_srv_zero, clock, reset, rsp_valid && rsp.status != ST_OK, rsp.found_server == '0)
endmodule

bind consistent_hash_ring_lookup_core chrl_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp(rsp_ch.payload)
);
